// File: design/dlpr_pkg.sv
`timescale 1ns / 1ps

package dlpr_pkg;

  localparam int COUNT_W = 19;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = COUNT_W'(6553);
  localparam logic [COUNT_W-1:0] HOLD_RESET     = COUNT_W'(288358);

  typedef enum logic [1:0] {
    PH_DISABLED = 2'd0,
    PH_WAITING  = 2'd1,
    PH_DEBOUNCE = 2'd2,
    PH_HOLDING  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_HOLD     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic               detector_enable;
    logic [COUNT_W-1:0] debounce_ticks;
    logic [COUNT_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic   reset_request;
    phase_t phase;
  } result_t;

endpackage

// File: design/dlpr_regs.sv
`timescale 1ns / 1ps

module dlpr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlpr_pkg::ADDR_W-1:0] paddr,
  input  logic [dlpr_pkg::DATA_W-1:0] pwdata,
  output logic [dlpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dlpr_pkg::cfg_t              cfg
);
  import dlpr_pkg::*;

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detector_enable <= 1'b0;
      cfg.debounce_ticks  <= DEBOUNCE_RESET;
      cfg.hold_ticks      <= HOLD_RESET;
    end else if (wr_en) begin
      case (index)
        REG_ENABLE:   cfg.detector_enable <= pwdata[0];
        REG_DEBOUNCE: cfg.debounce_ticks  <= pwdata[COUNT_W-1:0];
        REG_HOLD:     cfg.hold_ticks      <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_ENABLE:   prdata = DATA_W'(cfg.detector_enable);
      REG_DEBOUNCE: prdata = DATA_W'(cfg.debounce_ticks);
      REG_HOLD:     prdata = DATA_W'(cfg.hold_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: design/dlpr_fsm.sv
`timescale 1ns / 1ps

module dlpr_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              up_key_level,
  input  logic              down_key_level,
  input  dlpr_pkg::cfg_t    cfg,
  output dlpr_pkg::result_t res
);
  import dlpr_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  phase_t             cur;
  logic [COUNT_W-1:0] ticks_left;
  logic [COUNT_W-1:0] ticks_left_next;
  logic [COUNT_W-1:0] cur_ticks;
  logic               up_down;
  logic               dn_down;
  logic               expire;
  logic               request;

  assign up_down = !up_key_level;
  assign dn_down = !down_key_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DISABLED;
      ticks_left <= '0;
    end else if (step) begin
      phase      <= phase_next;
      ticks_left <= ticks_left_next;
    end
  end

  always_comb begin
    cur             = (phase == PH_DISABLED) ? PH_WAITING : phase;
    cur_ticks       = (phase == PH_DISABLED) ? '0 : ticks_left;
    expire          = (cur_ticks <= COUNT_W'(1));
    phase_next      = cur;
    ticks_left_next = expire ? '0 : cur_ticks - COUNT_W'(1);
    request         = 1'b0;
    if (!cfg.detector_enable) begin
      phase_next      = PH_DISABLED;
      ticks_left_next = '0;
    end else begin
      case (cur)
        PH_WAITING: begin
          ticks_left_next = cur_ticks;
          if (up_down || dn_down) begin
            phase_next      = PH_DEBOUNCE;
            ticks_left_next = cfg.debounce_ticks;
          end
        end
        PH_DEBOUNCE, PH_HOLDING: begin
          if ((cur == PH_DEBOUNCE) ? expire : !(up_down && dn_down)) begin
            // settle on the current key levels
            if (up_down && dn_down) begin
              phase_next      = PH_HOLDING;
              ticks_left_next = cfg.hold_ticks;
            end else if (up_down || dn_down) begin
              phase_next      = PH_DEBOUNCE;
              ticks_left_next = cfg.debounce_ticks;
            end else begin
              phase_next      = PH_WAITING;
              ticks_left_next = '0;
            end
          end else if (cur == PH_HOLDING && expire) begin
            request         = 1'b1;
            phase_next      = PH_WAITING;
            ticks_left_next = '0;
          end
        end
        default: begin
          phase_next      = PH_DISABLED;
          ticks_left_next = '0;
        end
      endcase
    end
    res.reset_request = request;
    res.phase         = phase_next;
  end

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WAITING || phase == PH_DISABLED) |-> ticks_left == '0)
    else $error("count not clear while idle");

  a_request_from_hold: assert property (@(posedge clk) disable iff (rst)
    (step && res.reset_request) |-> (phase == PH_HOLDING && cfg.detector_enable))
    else $error("reset request outside hold");

  a_disable_forces: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.detector_enable) |=> (phase == PH_DISABLED && ticks_left == '0))
    else $error("disable not applied");

  a_request_returns: assert property (@(posedge clk) disable iff (rst)
    (step && res.reset_request) |=> phase == PH_WAITING)
    else $error("no return to waiting after request");

endmodule

// File: design/dlpr_out.sv
`timescale 1ns / 1ps

module dlpr_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              step,
  input  dlpr_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              reset_request,
  output logic [1:0]        detector_state
);
  import dlpr_pkg::*;

  result_t held;

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held <= res;
    end
  end

  assign reset_request  = held.reset_request;
  assign detector_state = held.phase;

endmodule

// File: design/debounced_long_press_reset.sv
`timescale 1ns / 1ps
// Hold-to-reset detector for two active-low keys.
// Input channel: one item per timer tick with up_key_level and down_key_level
// (0 = pressed), handshake in_valid / in_stall. Output channel: one item per
// input item with reset_request (one-tick pulse) and detector_state
// (0 disabled, 1 waiting, 2 debouncing, 3 holding), handshake out_valid /
// out_stall.
// The result is registered and appears on the outputs in the cycle after the
// input item is taken. The block takes one item per cycle while in_stall is
// low; phase and countdown update together on each accepted item, and the
// output register lets a new item in while the previous result is being taken.
// When the receiver stalls, the result holds and in_stall rises only while
// the output register is full and stalled.
// Reset: detector disabled, debounce 6553 ticks, hold 288358 ticks, phase
// disabled, output empty. Configure over the APB port (enable at 0x0,
// debounce at 0x4, hold at 0x8) while no item is in flight.
module debounced_long_press_reset (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlpr_pkg::ADDR_W-1:0] paddr,
  input  logic [dlpr_pkg::DATA_W-1:0] pwdata,
  output logic [dlpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        up_key_level,
  input  logic                        down_key_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        reset_request,
  output logic [1:0]                  detector_state
);
  import dlpr_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    step;

  dlpr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlpr_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .up_key_level   (up_key_level),
    .down_key_level (down_key_level),
    .cfg            (cfg),
    .res            (res)
  );

  dlpr_out u_out (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .step           (step),
    .res            (res),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reset_request  (reset_request),
    .detector_state (detector_state)
  );

endmodule
